[design/nst_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package nst_pkg;

	localparam logic OP_BEGIN = 1'b0;
	localparam logic OP_END   = 1'b1;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_CALC,
		BK_COMMIT
	} bk_state_t;

	typedef struct packed {
		logic        end_op;
		logic        in_range;
		logic [3:0]  thread_id;
		logic [31:0] timestamp;
	} nst_item_t;

	typedef struct packed {
		logic pop;
		logic clearing;
	} nst_bk_status_t;

	typedef struct packed {
		logic [15:0] nesting;
		logic        started;
		logic [31:0] begin_time;
		logic [31:0] calls;
		logic [47:0] cost;
	} nst_entry_t;

	localparam int ENTRY_W = $bits(nst_entry_t);

endpackage
`default_nettype wire

[design/nst_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module nst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

[design/nst_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module nst_front #(
	parameter int THREADS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic                  operation,
	input  wire logic [3:0]            thread_id,
	input  wire logic [31:0]           timestamp,
	output logic                       q_valid,
	output nst_pkg::nst_item_t         q_item,
	input  wire nst_pkg::nst_bk_status_t bk_status
);

	nst_pkg::nst_item_t slot_q [2];
	nst_pkg::nst_item_t new_item;
	logic               wr_q;
	logic               rd_q;
	logic [1:0]         cnt_q;
	logic               push;
	logic               full;
	logic [31:0]        tid32;

	assign full    = (cnt_q == 2'd2);
	assign busy    = full || bk_status.clearing;
	assign push    = start && !busy;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item  = slot_q[rd_q];
	assign tid32   = 32'(thread_id);

	always_comb begin
		new_item.end_op    = operation;
		new_item.in_range  = (tid32 < 32'(THREADS));
		new_item.thread_id = thread_id;
		new_item.timestamp = timestamp;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (bk_status.pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, bk_status.pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

[design/nst_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module nst_back #(
	parameter int THREADS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                q_valid,
	input  wire nst_pkg::nst_item_t  q_item,
	output nst_pkg::nst_bk_status_t  bk_status,
	output logic                     done,
	output logic [31:0]              thread_calls,
	output logic [47:0]              thread_cost,
	output logic signed [15:0]       thread_nesting,
	output logic [31:0]              elapsed,
	output logic                     cost_taken,
	output logic [31:0]              total_calls,
	output logic [47:0]              total_cost,
	output logic                     unmatched
);

	localparam int AW = (THREADS > 1) ? $clog2(THREADS) : 1;

	nst_pkg::bk_state_t state_q, state_d;
	logic [AW-1:0]      clr_q;
	logic               clr_last;
	nst_pkg::nst_item_t item_q;
	logic [31:0]        head_tid32;
	logic [31:0]        item_tid32;
	logic [AW-1:0]      head_addr;
	logic [AW-1:0]      item_addr;

	logic pop, clearing, calc_en, commit_en;

	logic                     ram_we;
	logic [AW-1:0]            ram_waddr;
	logic [nst_pkg::ENTRY_W-1:0] ram_wdata;
	logic [nst_pkg::ENTRY_W-1:0] ram_rdata;

	nst_pkg::nst_entry_t rd_entry;
	nst_pkg::nst_entry_t calc_entry;
	logic [15:0]         nest_dec;
	logic [31:0]         calc_elapsed;
	logic                calc_taken;
	logic                calc_acc;

	nst_pkg::nst_entry_t entry_s1;
	logic [31:0]         elapsed_s1;
	logic                taken_s1;
	logic                acc_s1;

	nst_pkg::nst_entry_t commit_entry;
	logic [15:0]         tot_nest_q, tot_nest_d;
	logic [31:0]         tot_calls_q, tot_calls_d;
	logic [47:0]         tot_cost_q, tot_cost_d;

	logic                done_q;
	logic [31:0]         calls_out_q;
	logic [47:0]         cost_out_q;
	logic [15:0]         nest_out_q;
	logic [31:0]         elapsed_out_q;
	logic                taken_out_q;
	logic                unmatched_q;

	assign head_tid32 = 32'(q_item.thread_id);
	assign item_tid32 = 32'(item_q.thread_id);
	assign head_addr  = head_tid32[AW-1:0];
	assign item_addr  = item_tid32[AW-1:0];
	assign clr_last   = (clr_q == AW'(THREADS - 1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			nst_pkg::BK_CLEAR:  if (clr_last) state_d = nst_pkg::BK_IDLE;
			nst_pkg::BK_IDLE:   if (q_valid) state_d = nst_pkg::BK_CALC;
			nst_pkg::BK_CALC:   state_d = nst_pkg::BK_COMMIT;
			nst_pkg::BK_COMMIT: state_d = nst_pkg::BK_IDLE;
			default:            state_d = nst_pkg::BK_CLEAR;
		endcase
	end

	always_comb begin
		pop       = 1'b0;
		clearing  = 1'b0;
		calc_en   = 1'b0;
		commit_en = 1'b0;
		case (state_q)
			nst_pkg::BK_CLEAR:  clearing = 1'b1;
			nst_pkg::BK_IDLE:   pop = q_valid;
			nst_pkg::BK_CALC:   calc_en = 1'b1;
			nst_pkg::BK_COMMIT: commit_en = 1'b1;
			default:            clearing = 1'b0;
		endcase
	end

	assign bk_status.pop      = pop;
	assign bk_status.clearing = clearing;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nst_pkg::BK_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (clearing) begin
				clr_q <= clr_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= q_item;
		end
	end

	assign ram_we    = clearing || (commit_en && item_q.in_range);
	assign ram_waddr = clearing ? clr_q : item_addr;
	assign ram_wdata = clearing ? '0 : commit_entry;

	nst_ram #(
		.WIDTH(nst_pkg::ENTRY_W),
		.DEPTH(THREADS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (pop),
		.raddr(head_addr),
		.rdata(ram_rdata)
	);

	assign rd_entry = ram_rdata;
	assign nest_dec = rd_entry.nesting - 16'd1;

	always_comb begin
		calc_entry   = rd_entry;
		calc_elapsed = '0;
		calc_taken   = 1'b0;
		calc_acc     = 1'b0;
		if (item_q.end_op == nst_pkg::OP_END) begin
			calc_entry.nesting = nest_dec;
			if ((nest_dec == 16'd0 || nest_dec[15]) && rd_entry.started) begin
				calc_taken   = 1'b1;
				calc_elapsed = item_q.timestamp - rd_entry.begin_time;
				calc_acc     = (nest_dec == 16'd0);
			end
		end else begin
			calc_entry.calls   = rd_entry.calls + 32'd1;
			calc_entry.nesting = rd_entry.nesting + 16'd1;
			if (rd_entry.nesting == 16'd0) begin
				calc_entry.begin_time = item_q.timestamp;
				calc_entry.started    = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (calc_en) begin
			entry_s1   <= calc_entry;
			elapsed_s1 <= calc_elapsed;
			taken_s1   <= calc_taken && item_q.in_range;
			acc_s1     <= calc_acc;
		end
	end

	always_comb begin
		commit_entry = entry_s1;
		if (taken_s1) begin
			commit_entry.cost = acc_s1 ? (entry_s1.cost + 48'(elapsed_s1)) : 48'(elapsed_s1);
		end
		tot_nest_d  = tot_nest_q;
		tot_calls_d = tot_calls_q;
		tot_cost_d  = tot_cost_q;
		if (item_q.in_range) begin
			if (item_q.end_op == nst_pkg::OP_END) begin
				tot_nest_d = tot_nest_q - 16'd1;
				if (taken_s1) begin
					tot_cost_d = tot_cost_q + 48'(elapsed_s1);
				end
			end else begin
				tot_nest_d  = tot_nest_q + 16'd1;
				tot_calls_d = tot_calls_q + 32'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q      <= 1'b0;
			tot_nest_q  <= '0;
			tot_calls_q <= '0;
			tot_cost_q  <= '0;
			unmatched_q <= 1'b0;
		end else begin
			done_q <= commit_en;
			if (commit_en) begin
				tot_nest_q  <= tot_nest_d;
				tot_calls_q <= tot_calls_d;
				tot_cost_q  <= tot_cost_d;
				unmatched_q <= (tot_nest_d != 16'd0);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit_en) begin
			calls_out_q   <= item_q.in_range ? commit_entry.calls : '0;
			cost_out_q    <= item_q.in_range ? commit_entry.cost : '0;
			nest_out_q    <= item_q.in_range ? commit_entry.nesting : '0;
			elapsed_out_q <= taken_s1 ? elapsed_s1 : '0;
			taken_out_q   <= taken_s1;
		end
	end

	assign done           = done_q;
	assign thread_calls   = calls_out_q;
	assign thread_cost    = cost_out_q;
	assign thread_nesting = $signed(nest_out_q);
	assign elapsed        = elapsed_out_q;
	assign cost_taken     = taken_out_q;
	assign total_calls    = tot_calls_q;
	assign total_cost     = tot_cost_q;
	assign unmatched      = unmatched_q;

`ifndef SYNTHESIS
	a_done_after_commit: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == nst_pkg::BK_COMMIT))
		else $error("result strobe without a commit cycle");

	a_pop_to_commit: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> ##1 (state_q == nst_pkg::BK_COMMIT))
		else $error("transaction did not reach commit two cycles after pop");

	a_taken_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == nst_pkg::BK_COMMIT && taken_s1) |->
		(item_q.end_op == nst_pkg::OP_END && item_q.in_range))
		else $error("time measured on a begin or out-of-range transaction");

	a_totals_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != nst_pkg::BK_COMMIT) |=> ($stable(tot_nest_q) && $stable(tot_cost_q)))
		else $error("totals changed outside commit");

	a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		$past(clearing) && !clearing |-> (state_q == nst_pkg::BK_IDLE))
		else $error("clear pass did not end in idle");
`endif

endmodule
`default_nettype wire

[design/nested_section_timer_table_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// channel   direction  handshake              fields
// command   in         start && !busy         operation, thread_id, timestamp
// result    out        done (one cycle)       thread_calls, thread_cost, thread_nesting,
//                                             elapsed, cost_taken, total_calls,
//                                             total_cost, unmatched
//
// Each transaction passes through the back end as table read, measure, and accumulate and
// write back; the read-modify-write of the thread table through its registered read
// sets these steps, and the next transaction is taken only after write back.
// A 2-entry queue takes new transactions while the back end works; busy rises when full.
// After reset a clear pass writes THREADS table rows, one a cycle, with busy high.
// The result appears in the cycle after commit, for exactly one cycle; there is no stall.
module nested_section_timer_table_core #(
	parameter int THREADS = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire logic          operation,
	input  wire logic [3:0]    thread_id,
	input  wire logic [31:0]   timestamp,
	output logic               done,
	output logic [31:0]        thread_calls,
	output logic [47:0]        thread_cost,
	output logic signed [15:0] thread_nesting,
	output logic [31:0]        elapsed,
	output logic               cost_taken,
	output logic [31:0]        total_calls,
	output logic [47:0]        total_cost,
	output logic               unmatched
);

	logic                    q_valid;
	nst_pkg::nst_item_t      q_item;
	nst_pkg::nst_bk_status_t bk_status;

	nst_front #(
		.THREADS(THREADS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.operation(operation),
		.thread_id(thread_id),
		.timestamp(timestamp),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.bk_status(bk_status)
	);

	nst_back #(
		.THREADS(THREADS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.bk_status     (bk_status),
		.done          (done),
		.thread_calls  (thread_calls),
		.thread_cost   (thread_cost),
		.thread_nesting(thread_nesting),
		.elapsed       (elapsed),
		.cost_taken    (cost_taken),
		.total_calls   (total_calls),
		.total_cost    (total_cost),
		.unmatched     (unmatched)
	);

endmodule
`default_nettype wire
